// ===== design/tpbc_pkg.sv =====
`default_nettype none

package tpbc_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_DECK_LEVEL      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECK_NORMAL_MIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WATERLINE_LEVEL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_DEPTH      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOOT_HEIGHT     = 3'd4;

  // paint band codes
  localparam logic [2:0] BAND_UNDERWATER = 3'd0;
  localparam logic [2:0] BAND_BOOT       = 3'd1;
  localparam logic [2:0] BAND_TOPSIDE    = 3'd2;
  localparam logic [2:0] BAND_DECK       = 3'd3;
  localparam logic [2:0] BAND_TORN       = 3'd4;

  // per request flags that ride alongside the normal arithmetic
  typedef struct packed {
    logic torn;
    logic deck_hgt;
    logic below_lo;
    logic below_hi;
    logic nz_neg;
    logic nz_pos;
  } flag_t;

endpackage

`default_nettype wire

// ===== design/triangle_paint_band_classifier.sv =====
`default_nettype none

// channel   direction  ports                                       handshake
// -------   ---------  ------------------------------------------  ---------------------------
// request   in         vertex_{a,b,c}_{x,y,z}_i, torn_flag_i       start & !busy at clock edge
// result    out        band_code_o                                 band_valid_o, one cycle
// config    in         cfg_idx_i, cfg_wdata_i                      cfg_we_i at clock edge
//
// one request may enter every cycle; the result leaves from the stage 11 band register
// the pipeline depth is set by the normal test: cross products, squaring of the 66 bit
// normal components and the threshold product, the last two split over 32 bit multipliers
// busy never rises: the pipeline has no stall point, as the receiver cannot hold off
// rst_ni clears the valid bits and the configuration registers (all levels zero)

module triangle_paint_band_classifier
  import tpbc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // request channel
  input  logic                 start,
  output logic                 busy,
  input  logic signed [31:0]   vertex_a_x_i,
  input  logic signed [31:0]   vertex_a_y_i,
  input  logic signed [31:0]   vertex_a_z_i,
  input  logic signed [31:0]   vertex_b_x_i,
  input  logic signed [31:0]   vertex_b_y_i,
  input  logic signed [31:0]   vertex_b_z_i,
  input  logic signed [31:0]   vertex_c_x_i,
  input  logic signed [31:0]   vertex_c_y_i,
  input  logic signed [31:0]   vertex_c_z_i,
  input  logic                 torn_flag_i,
  // result channel
  output logic                 band_valid_o,
  output logic [2:0]           band_code_o,
  // configuration port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]          cfg_wdata_i
);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic signed [31:0] deck_level_q;
  logic signed [15:0] deck_normal_min_q;
  logic signed [31:0] waterline_level_q;
  logic [30:0]        boot_depth_q;
  logic [30:0]        boot_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deck_level_q      <= '0;
      deck_normal_min_q <= '0;
      waterline_level_q <= '0;
      boot_depth_q      <= '0;
      boot_height_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_DECK_LEVEL:      deck_level_q      <= cfg_wdata_i;
        REG_DECK_NORMAL_MIN: deck_normal_min_q <= cfg_wdata_i[15:0];
        REG_WATERLINE_LEVEL: waterline_level_q <= cfg_wdata_i;
        REG_BOOT_DEPTH:      boot_depth_q      <= cfg_wdata_i[30:0];
        REG_BOOT_HEIGHT:     boot_height_q     <= cfg_wdata_i[30:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // derived thresholds, refreshed every cycle from the configuration
  // centroid tests compare the z sum against three times each level, so the
  // fraction width cancels and no division is needed
  // ---------------------------------------------------------------------------
  logic signed [33:0] deck_ext;
  logic signed [32:0] lo_lvl;
  logic signed [32:0] hi_lvl;
  logic signed [33:0] deck_thr_d, deck_thr_q;
  logic signed [34:0] lo_thr_d, lo_thr_q;
  logic signed [34:0] hi_thr_d, hi_thr_q;
  logic [15:0]        t_neg;
  logic [15:0]        t_mag;
  logic [31:0]        t_sq_d, t_sq_q;
  logic               t_le0;

  assign deck_ext   = 34'(deck_level_q);
  assign deck_thr_d = deck_ext + (deck_ext <<< 1);
  // level sums are formed one bit wider so they never wrap
  assign lo_lvl     = 33'(waterline_level_q) - $signed({2'b00, boot_depth_q});
  assign hi_lvl     = 33'(waterline_level_q) + $signed({2'b00, boot_height_q});
  assign lo_thr_d   = 35'(lo_lvl) + (35'(lo_lvl) <<< 1);
  assign hi_thr_d   = 35'(hi_lvl) + (35'(hi_lvl) <<< 1);

  // squared normal threshold; the sign is handled at the final compare
  assign t_neg  = 16'(-deck_normal_min_q);
  assign t_mag  = deck_normal_min_q[15] ? t_neg : deck_normal_min_q;
  assign t_sq_d = t_mag * t_mag;
  assign t_le0  = deck_normal_min_q[15] | ~(|deck_normal_min_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deck_thr_q <= '0;
      lo_thr_q   <= '0;
      hi_thr_q   <= '0;
      t_sq_q     <= '0;
    end else begin
      deck_thr_q <= deck_thr_d;
      lo_thr_q   <= lo_thr_d;
      hi_thr_q   <= hi_thr_d;
      t_sq_q     <= t_sq_d;
    end
  end

  // ---------------------------------------------------------------------------
  // pipeline control: valid bits only, no stall
  // ---------------------------------------------------------------------------
  logic        accept;
  logic [10:1] vld_q;
  logic        band_valid_q;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= '0;
      band_valid_q <= 1'b0;
    end else begin
      vld_q        <= {vld_q[9:1], accept};
      band_valid_q <= vld_q[10];
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: edge vectors and centroid z sum
  // ---------------------------------------------------------------------------
  logic signed [32:0] e1x_q, e1y_q, e1z_q;
  logic signed [32:0] e2x_q, e2y_q, e2z_q;
  logic signed [33:0] zsum_q;
  logic               torn1_q;

  always_ff @(posedge clk_i) begin
    e1x_q   <= 33'(vertex_b_x_i) - 33'(vertex_a_x_i);
    e1y_q   <= 33'(vertex_b_y_i) - 33'(vertex_a_y_i);
    e1z_q   <= 33'(vertex_b_z_i) - 33'(vertex_a_z_i);
    e2x_q   <= 33'(vertex_c_x_i) - 33'(vertex_a_x_i);
    e2y_q   <= 33'(vertex_c_y_i) - 33'(vertex_a_y_i);
    e2z_q   <= 33'(vertex_c_z_i) - 33'(vertex_a_z_i);
    zsum_q  <= 34'(vertex_a_z_i) + 34'(vertex_b_z_i) + 34'(vertex_c_z_i);
    torn1_q <= torn_flag_i;
  end

  // ---------------------------------------------------------------------------
  // stage 2: six cross product terms, centroid height tests
  // ---------------------------------------------------------------------------
  logic signed [65:0] p_yz_q, p_zy_q, p_zx_q, p_xz_q, p_xy_q, p_yx_q;
  flag_t              fl_q [2:10];
  flag_t              fl2_d;

  always_comb begin
    fl2_d          = '0;
    fl2_d.torn     = torn1_q;
    fl2_d.deck_hgt = zsum_q >= deck_thr_q;
    fl2_d.below_lo = 35'(zsum_q) < lo_thr_q;
    fl2_d.below_hi = 35'(zsum_q) < hi_thr_q;
  end

  always_ff @(posedge clk_i) begin
    p_yz_q  <= e1y_q * e2z_q;
    p_zy_q  <= e1z_q * e2y_q;
    p_zx_q  <= e1z_q * e2x_q;
    p_xz_q  <= e1x_q * e2z_q;
    p_xy_q  <= e1x_q * e2y_q;
    p_yx_q  <= e1y_q * e2x_q;
    fl_q[2] <= fl2_d;
  end

  // ---------------------------------------------------------------------------
  // stage 3: normal components
  // ---------------------------------------------------------------------------
  logic signed [66:0] nx_q, ny_q, nz_q;

  always_ff @(posedge clk_i) begin
    nx_q    <= 67'(p_yz_q) - 67'(p_zy_q);
    ny_q    <= 67'(p_zx_q) - 67'(p_xz_q);
    nz_q    <= 67'(p_xy_q) - 67'(p_yx_q);
    fl_q[3] <= fl_q[2];
  end

  // ---------------------------------------------------------------------------
  // stage 4: magnitudes and the sign of the normal z
  // ---------------------------------------------------------------------------
  logic signed [66:0] nx_neg, ny_neg, nz_neg;
  logic [65:0]        mx_q, my_q, mz_q;
  flag_t              fl4_d;

  assign nx_neg = -nx_q;
  assign ny_neg = -ny_q;
  assign nz_neg = -nz_q;

  always_comb begin
    fl4_d        = fl_q[3];
    fl4_d.nz_neg = nz_q[66];
    fl4_d.nz_pos = ~nz_q[66] & (|nz_q);
  end

  always_ff @(posedge clk_i) begin
    mx_q    <= nx_q[66] ? nx_neg[65:0] : nx_q[65:0];
    my_q    <= ny_q[66] ? ny_neg[65:0] : ny_q[65:0];
    mz_q    <= nz_q[66] ? nz_neg[65:0] : nz_q[65:0];
    fl_q[4] <= fl4_d;
  end

  // ---------------------------------------------------------------------------
  // stage 5: squaring split into high and low halves
  // m^2 = hi^2 * 2^64 + 2 * hi * lo * 2^32 + lo^2
  // ---------------------------------------------------------------------------
  logic [67:0] hh_x_q, hh_y_q, hh_z_q;
  logic [65:0] hl_x_q, hl_y_q, hl_z_q;
  logic [63:0] ll_x_q, ll_y_q, ll_z_q;

  always_ff @(posedge clk_i) begin
    hh_x_q  <= mx_q[65:32] * mx_q[65:32];
    hh_y_q  <= my_q[65:32] * my_q[65:32];
    hh_z_q  <= mz_q[65:32] * mz_q[65:32];
    hl_x_q  <= mx_q[65:32] * mx_q[31:0];
    hl_y_q  <= my_q[65:32] * my_q[31:0];
    hl_z_q  <= mz_q[65:32] * mz_q[31:0];
    ll_x_q  <= mx_q[31:0] * mx_q[31:0];
    ll_y_q  <= my_q[31:0] * my_q[31:0];
    ll_z_q  <= mz_q[31:0] * mz_q[31:0];
    fl_q[5] <= fl_q[4];
  end

  // ---------------------------------------------------------------------------
  // stage 6: squares of the normal components
  // ---------------------------------------------------------------------------
  logic [131:0] sx_q, sy_q, sz_q;

  always_ff @(posedge clk_i) begin
    sx_q    <= (132'(hh_x_q) << 64) + (132'(hl_x_q) << 33) + 132'(ll_x_q);
    sy_q    <= (132'(hh_y_q) << 64) + (132'(hl_y_q) << 33) + 132'(ll_y_q);
    sz_q    <= (132'(hh_z_q) << 64) + (132'(hl_z_q) << 33) + 132'(ll_z_q);
    fl_q[6] <= fl_q[5];
  end

  // ---------------------------------------------------------------------------
  // stage 7: squared normal length
  // ---------------------------------------------------------------------------
  logic [133:0] n2_q;
  logic [131:0] nz2_7_q, nz2_8_q, nz2_9_q, nz2_10_q;

  always_ff @(posedge clk_i) begin
    n2_q    <= 134'(sx_q) + 134'(sy_q) + 134'(sz_q);
    nz2_7_q <= sz_q;
    fl_q[7] <= fl_q[6];
  end

  // ---------------------------------------------------------------------------
  // stage 8: threshold squared times length squared, in 32 bit slices
  // ---------------------------------------------------------------------------
  logic [63:0] q0_q, q1_q, q2_q, q3_q;
  logic [37:0] q4_8_q, q4_9_q;

  always_ff @(posedge clk_i) begin
    q0_q    <= t_sq_q * n2_q[31:0];
    q1_q    <= t_sq_q * n2_q[63:32];
    q2_q    <= t_sq_q * n2_q[95:64];
    q3_q    <= t_sq_q * n2_q[127:96];
    q4_8_q  <= t_sq_q * n2_q[133:128];
    nz2_8_q <= nz2_7_q;
    fl_q[8] <= fl_q[7];
  end

  // ---------------------------------------------------------------------------
  // stage 9: pairwise slice sums
  // ---------------------------------------------------------------------------
  logic [95:0] r01_q, r23_q;

  always_ff @(posedge clk_i) begin
    r01_q   <= 96'(q0_q) + (96'(q1_q) << 32);
    r23_q   <= 96'(q2_q) + (96'(q3_q) << 32);
    q4_9_q  <= q4_8_q;
    nz2_9_q <= nz2_8_q;
    fl_q[9] <= fl_q[8];
  end

  // ---------------------------------------------------------------------------
  // stage 10: right hand side of the normal test
  // ---------------------------------------------------------------------------
  logic [165:0] rhs_q;

  always_ff @(posedge clk_i) begin
    rhs_q    <= 166'(r01_q) + (166'(r23_q) << 64) + (166'(q4_9_q) << 128);
    nz2_10_q <= nz2_9_q;
    fl_q[10] <= fl_q[9];
  end

  // ---------------------------------------------------------------------------
  // stage 11: normal test and band priority
  // nz^2 * 2^28 against t^2 * |n|^2; a zero area triangle has nz = 0 and so
  // falls out of the sign rules without a case of its own
  // ---------------------------------------------------------------------------
  logic [165:0] lhs;
  logic         normal_ok;
  logic [2:0]   band_d, band_q;

  assign lhs = 166'(nz2_10_q) << 28;

  always_comb begin
    if (t_le0) begin
      normal_ok = ~fl_q[10].nz_neg | (lhs <= rhs_q);
    end else begin
      normal_ok = fl_q[10].nz_pos & (lhs >= rhs_q);
    end

    if (fl_q[10].torn) begin
      band_d = BAND_TORN;
    end else if (fl_q[10].deck_hgt && normal_ok) begin
      band_d = BAND_DECK;
    end else if (fl_q[10].below_lo) begin
      band_d = BAND_UNDERWATER;
    end else if (fl_q[10].below_hi) begin
      band_d = BAND_BOOT;
    end else begin
      band_d = BAND_TOPSIDE;
    end
  end

  always_ff @(posedge clk_i) begin
    band_q <= band_d;
  end

  assign band_valid_o = band_valid_q;
  assign band_code_o  = band_q;

endmodule

`default_nettype wire
